// ----- src/leht_pkg.sv -----
// Types, codes and helpers shared by the layer extent hull tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package leht_pkg;

    localparam int H_W     = 32;  // Q16.16 height width
    localparam int LAYER_W = 3;   // layer number / count width
    localparam int CFG_W   = 3;   // configuration index width

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_COUNT     = 3'd0;
    localparam logic [CFG_W-1:0] CFG_BND_FIRST = 3'd1;
    localparam int               CFG_BND_NUM   = 4;

    // commands
    localparam logic CMD_UPDATE  = 1'b0;
    localparam logic CMD_READOUT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_RECORD  = 2'd3;

    typedef struct packed {
        logic                  command;
        logic signed [H_W-1:0] object_top;
        logic signed [H_W-1:0] object_bottom;
        logic signed [H_W-1:0] shift;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [LAYER_W-1:0]    layer_index;
        logic                  filled;
        logic signed [H_W-1:0] rel_lower;
        logic signed [H_W-1:0] rel_upper;
        logic                  last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic               latch_in;   // capture accepted item
        logic               do_sum;     // register saturated top / bottom
        logic               do_check;   // register layer span
        logic               issue;      // push layer into merge pipe
        logic [LAYER_W-1:0] idx;        // walked layer (issue or readout)
        logic               load_out;   // load output register
        logic               out_record; // readout record, else plain status
        logic [1:0]         out_status;
        logic               out_last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [LAYER_W-1:0] n;          // boundaries in use
        logic               bot_gt_top;
        logic               bot_eq_top;
        logic               pipe_busy;
    } t_dp_stat;

    // saturate a 33-bit sum / difference to signed 32 bits
    function automatic logic signed [H_W-1:0] f_sat32(input logic signed [H_W:0] x);
        logic signed [H_W-1:0] r;
        if (x[H_W] != x[H_W-1]) begin
            r = x[H_W] ? {1'b1, {(H_W-1){1'b0}}} : {1'b0, {(H_W-1){1'b1}}};
        end else begin
            r = x[H_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/leht_ctrl.sv -----
// Sequencer of the hull tracker: item intake, layer walk, result emission.
// Depends on leht_pkg; drives leht_dpath through t_dp_cmd.
`default_nettype none

module leht_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_accept,
    input  wire logic              i_readout,
    input  wire logic              i_out_stall,
    input  wire leht_pkg::t_dp_stat i_stat,
    output leht_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy,
    output logic                   o_out_valid
);
    import leht_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUM    = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_REPORT = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [LAYER_W-1:0] r_idx, n_idx;
    logic [1:0]         r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic               out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_status      = r_status;
        o_cmd         = '0;
        o_cmd.latch_in = i_in_accept;
        o_cmd.idx     = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_accept) begin
                    n_idx   = '0;
                    n_state = (i_readout == CMD_READOUT) ? S_READ : S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.do_sum = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.do_check = 1'b1;
                priority if (i_stat.n == '0) begin
                    n_status = ST_IGNORED;
                    n_state  = S_REPORT;
                end else if (i_stat.bot_gt_top) begin
                    n_status = ST_ERROR;
                    n_state  = S_REPORT;
                end else if (i_stat.bot_eq_top) begin
                    n_status = ST_IGNORED;
                    n_state  = S_REPORT;
                end else begin
                    n_status = ST_UPDATED;
                    n_idx    = '0;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.issue = 1'b1;
                if (r_idx == i_stat.n) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + LAYER_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = r_status;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_record = 1'b1;
                    o_cmd.out_status = ST_RECORD;
                    o_cmd.out_last   = (r_idx == i_stat.n);
                    if (r_idx == i_stat.n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + LAYER_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_status    <= ST_UPDATED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // walk and readout never pass the last layer
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_READ) |-> (r_idx <= i_stat.n))
        else $error("layer walk index beyond last layer");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten");

    // the drain holds until the merge pipe is empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && i_stat.pipe_busy) |=> (r_state == S_DRAIN))
        else $error("drain left with merge in flight");

    // a readout item goes straight to record emission
    a_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_accept && i_readout == CMD_READOUT) |=> (r_state == S_READ))
        else $error("readout not started");

endmodule

`default_nettype wire

// ----- src/leht_dpath.sv -----
// Datapath of the hull tracker: boundary registers, layer records,
// span compare, three-stage clip / subtract / merge pipe, output register.
// Depends on leht_pkg; steered by leht_ctrl.
`default_nettype none

module leht_dpath #(
    parameter int MAX_BOUNDARIES = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [leht_pkg::CFG_W-1:0] i_cfg_idx,
    input  wire logic [leht_pkg::H_W-1:0] i_cfg_data,
    input  wire leht_pkg::t_in_item       i_in_item,
    input  wire leht_pkg::t_dp_cmd        i_cmd,
    output leht_pkg::t_dp_stat            o_stat,
    output leht_pkg::t_out_item           o_out_item
);
    import leht_pkg::*;

    localparam int NL = MAX_BOUNDARIES + 1;

    logic [LAYER_W-1:0]    r_count;
    logic signed [H_W-1:0] r_bnd [MAX_BOUNDARIES];
    logic [LAYER_W-1:0]    n_used;

    logic signed [H_W-1:0] r_obj_top, r_obj_bot, r_shift;
    logic signed [H_W-1:0] r_top, r_bot;
    logic [LAYER_W-1:0]    r_ti, r_bi, n_ti, n_bi;

    // merge pipe
    logic signed [H_W-1:0] r_prev;
    logic                  r_s1_v, r_s2_v;
    logic [LAYER_W-1:0]    r_s1_idx, r_s2_idx;
    logic signed [H_W-1:0] r_s1_lo, r_s1_hi, r_s1_ref;
    logic signed [H_W-1:0] r_s2_rl, r_s2_ru;
    logic signed [H_W-1:0] cur, ref_h, clip_lo, clip_hi;
    logic                  in_span;

    // layer records
    logic [NL-1:0]         r_filled;
    logic signed [H_W-1:0] r_rec_lo [NL];
    logic signed [H_W-1:0] r_rec_hi [NL];
    logic [LAYER_W-1:0]    rd_idx;
    logic                  rd_filled;
    logic signed [H_W-1:0] rd_lo, rd_hi;

    t_out_item             r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < MAX_BOUNDARIES; k++) begin
                r_bnd[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_COUNT) begin
                r_count <= i_cfg_data[LAYER_W-1:0];
            end
            for (int k = 0; k < MAX_BOUNDARIES; k++) begin
                if (k < CFG_BND_NUM && i_cfg_idx == CFG_BND_FIRST + CFG_W'(k)) begin
                    r_bnd[k] <= i_cfg_data;
                end
            end
        end
    end

    assign n_used = (r_count > LAYER_W'(MAX_BOUNDARIES)) ? LAYER_W'(MAX_BOUNDARIES)
                                                         : r_count;

    // item capture and saturated offset
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_obj_top <= i_in_item.object_top;
            r_obj_bot <= i_in_item.object_bottom;
            r_shift   <= i_in_item.shift;
        end
        if (i_cmd.do_sum) begin
            r_top <= f_sat32({r_obj_top[H_W-1], r_obj_top} + {r_shift[H_W-1], r_shift});
            r_bot <= f_sat32({r_obj_bot[H_W-1], r_obj_bot} + {r_shift[H_W-1], r_shift});
        end
        if (i_cmd.do_check) begin
            r_ti <= n_ti;
            r_bi <= n_bi;
        end
    end

    // span: first layer = boundaries at or above top, last = boundaries above bottom
    always_comb begin
        n_ti = '0;
        n_bi = '0;
        for (int k = 0; k < MAX_BOUNDARIES; k++) begin
            if (LAYER_W'(k) < n_used) begin
                if (r_bnd[k] >= r_top) begin
                    n_ti = n_ti + LAYER_W'(1);
                end
                if (r_bnd[k] > r_bot) begin
                    n_bi = n_bi + LAYER_W'(1);
                end
            end
        end
    end

    // stage 1: clip to the layer
    always_comb begin
        cur = '0;
        for (int k = 0; k < MAX_BOUNDARIES; k++) begin
            if (i_cmd.idx == LAYER_W'(k)) begin
                cur = r_bnd[k];
            end
        end
        ref_h   = (i_cmd.idx == '0) ? cur : r_prev;
        clip_hi = (i_cmd.idx != '0 && r_top > ref_h) ? ref_h : r_top;
        clip_lo = (i_cmd.idx != n_used && r_bot < cur) ? cur : r_bot;
        in_span = (i_cmd.idx >= r_ti) && (i_cmd.idx <= r_bi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.issue && in_span;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prev   <= cur;
            r_s1_idx <= i_cmd.idx;
            r_s1_lo  <= clip_lo;
            r_s1_hi  <= clip_hi;
            r_s1_ref <= ref_h;
        end
        // stage 2: relative to the layer reference
        r_s2_idx <= r_s1_idx;
        r_s2_rl  <= f_sat32({r_s1_lo[H_W-1], r_s1_lo} - {r_s1_ref[H_W-1], r_s1_ref});
        r_s2_ru  <= f_sat32({r_s1_hi[H_W-1], r_s1_hi} - {r_s1_ref[H_W-1], r_s1_ref});
    end

    // record read: merge stage while the pipe runs, readout otherwise
    assign rd_idx = r_s2_v ? r_s2_idx : i_cmd.idx;

    always_comb begin
        rd_filled = 1'b0;
        rd_lo     = '0;
        rd_hi     = '0;
        for (int k = 0; k < NL; k++) begin
            if (rd_idx == LAYER_W'(k)) begin
                rd_filled = r_filled[k];
                rd_lo     = r_rec_lo[k];
                rd_hi     = r_rec_hi[k];
            end
        end
    end

    // stage 3: hull merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (r_s2_v) begin
            for (int k = 0; k < NL; k++) begin
                if (r_s2_idx == LAYER_W'(k)) begin
                    r_filled[k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            for (int k = 0; k < NL; k++) begin
                if (r_s2_idx == LAYER_W'(k)) begin
                    r_rec_lo[k] <= (!rd_filled || r_s2_rl < rd_lo) ? r_s2_rl : rd_lo;
                    r_rec_hi[k] <= (!rd_filled || r_s2_ru > rd_hi) ? r_s2_ru : rd_hi;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status <= i_cmd.out_status;
            r_out.last   <= i_cmd.out_last;
            if (i_cmd.out_record) begin
                r_out.layer_index <= i_cmd.idx;
                r_out.filled      <= rd_filled;
                r_out.rel_lower   <= rd_filled ? rd_lo : '0;
                r_out.rel_upper   <= rd_filled ? rd_hi : '0;
            end else begin
                r_out.layer_index <= '0;
                r_out.filled      <= 1'b0;
                r_out.rel_lower   <= '0;
                r_out.rel_upper   <= '0;
            end
        end
    end

    assign o_out_item       = r_out;
    assign o_stat.n         = n_used;
    assign o_stat.bot_gt_top = (r_bot > r_top);
    assign o_stat.bot_eq_top = (r_bot == r_top);
    assign o_stat.pipe_busy = r_s1_v || r_s2_v;

    // a merge always leaves its layer filled
    a_merge_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |=> r_filled[$past(r_s2_idx)])
        else $error("merged layer not marked filled");

    // merged layers lie within the span and the layer count
    a_s1_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> (r_s1_idx <= n_used && r_s1_idx >= r_ti && r_s1_idx <= r_bi))
        else $error("merge outside layer span");

    // the span counts never exceed the boundaries in use
    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_check |=> (r_ti <= n_used && r_bi <= n_used))
        else $error("layer span beyond boundary count");

endmodule

`default_nettype wire

// ----- src/layer_extent_hull_tracker.sv -----
// Top level of the layer extent hull tracker: ports and glue.
// Depends on leht_pkg, leht_ctrl and leht_dpath.
`default_nettype none

// Layer extent hull tracker. Up to MAX_BOUNDARIES descending boundary heights
// (Q16.16) split the height axis into boundary_count + 1 layers, layer 0 on
// top. An update item (command 0) offsets the object's top and bottom by
// shift with saturation, finds the layers it spans and folds the clipped
// interval, relative to each layer's upper boundary (for layer 0 the one
// below it), into that layer's record as a hull; it answers with one item:
// updated, ignored (no boundaries or zero height) or error (bottom above
// top, nothing changed). A readout item (command 1) answers with one record
// per layer, topmost first, last set on the final one. One item is in work
// at a time; o_in_stall is low only when the block is idle. An update that
// passes the checks goes through offset, span compare, a walk of all n + 1
// layers (n being the boundaries in use) through the clip / subtract / merge
// pipe one layer per cycle, pipe drain, then the output load. An ignored or
// refused update goes from the span compare straight to the output load.
// A readout gives one record per cycle while the output side takes them.
// Results wait in an output register and a stalled result holds the next
// load back. Configuration must be written through the plain write port
// only while the block is idle; the block does not enforce this. Index 0 is
// the boundary count, 1 to 4 the boundaries. Records survive count changes.
module layer_extent_hull_tracker #(
    parameter int MAX_BOUNDARIES = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [leht_pkg::CFG_W-1:0] i_cfg_idx,
    input  wire logic [leht_pkg::H_W-1:0]   i_cfg_data,
    // input items
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire leht_pkg::t_in_item         i_in_item,
    // result items
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output leht_pkg::t_out_item             o_out_item
);
    import leht_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     busy;
    logic     in_accept;

    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !busy;

    leht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_readout   (i_in_item.command),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_out_valid (o_out_valid)
    );

    leht_dpath #(
        .MAX_BOUNDARIES (MAX_BOUNDARIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
